/* sv/dtq_pkg.sv */
package dtq_pkg;

   localparam int DEPTH      = 16;
   localparam int TAG_BITS   = 8;
   localparam int IDX_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS   = $clog2(DEPTH + 1);
   localparam int DELTA_BITS = 17;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   localparam logic [1:0] KIND_ACCEPT = 2'd0;
   localparam logic [1:0] KIND_FULL   = 2'd1;
   localparam logic [1:0] KIND_FIRED  = 2'd2;

   typedef struct packed {
      logic signed [DELTA_BITS-1:0] delta;
      logic [TAG_BITS-1:0]          tag;
   } entry_type;

   // access to the queue by position counted from the head
   typedef struct packed {
      logic                rd_en;
      logic [IDX_BITS-1:0] rd_idx;
      logic                wr_en;
      logic [IDX_BITS-1:0] wr_idx;
      entry_type           wr_data;
      logic                pop;
   } mem_req_type;

   function automatic logic [IDX_BITS-1:0] ring_addr(input logic [IDX_BITS-1:0] head,
                                                      input logic [IDX_BITS-1:0] idx);
      logic [IDX_BITS:0] sum;
      sum = {1'b0, head} + {1'b0, idx};
      if (sum >= (IDX_BITS+1)'(DEPTH)) begin
         sum = sum - (IDX_BITS+1)'(DEPTH);
      end
      return sum[IDX_BITS-1:0];
   endfunction

endpackage

/* sv/dtq_ram.sv */
module dtq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [ADDR_BITS-1:0]     wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [ADDR_BITS-1:0]     rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/dtq_ring.sv */
module dtq_ring (
   input  logic                clock,
   input  logic                reset,
   input  dtq_pkg::mem_req_type mem_req,
   output dtq_pkg::entry_type  rd_data
);

   logic [dtq_pkg::IDX_BITS-1:0] head_ff;
   logic [dtq_pkg::IDX_BITS-1:0] head_in;
   logic [dtq_pkg::IDX_BITS-1:0] rd_addr;
   logic [dtq_pkg::IDX_BITS-1:0] wr_addr;
   logic [$bits(dtq_pkg::entry_type)-1:0] ram_rd_data;

   // the queue is a circular buffer, so popping the head is a pointer move
   assign rd_addr = dtq_pkg::ring_addr(head_ff, mem_req.rd_idx);
   assign wr_addr = dtq_pkg::ring_addr(head_ff, mem_req.wr_idx);

   always_comb begin
      head_in = head_ff;
      if (mem_req.pop) begin
         head_in = dtq_pkg::ring_addr(head_ff, dtq_pkg::IDX_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
      end else begin
         head_ff <= head_in;
      end
   end

   dtq_ram #(
      .WIDTH ($bits(dtq_pkg::entry_type)),
      .DEPTH (dtq_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_data = dtq_pkg::entry_type'(ram_rd_data);

endmodule

/* sv/delta_timer_queue.sv */
// insert: a ram read and a check per entry compared, a read and a write per entry moved up,
// then the new entry is written and the accepted result registered; a reject next cycle
// tick: a read and a check per entry examined (one ram read each), fired events issued from
// checks, the last one from ST_TK_END when the queue runs empty; results cannot stall
// busy stays high until the last result, if any, of a transaction is issued; one at a time
// synchronous reset empties the queue (count and head pointer); ram contents are kept
module delta_timer_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        req_cmd,
   input  logic [15:0] req_delay,
   input  logic [7:0]  req_event_tag,
   input  logic [15:0] req_tick_count,
   output logic        busy,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_fired_tag,
   output logic        rsp_last
);

   localparam int IB = dtq_pkg::IDX_BITS;
   localparam int CB = dtq_pkg::CNT_BITS;
   localparam int DB = dtq_pkg::DELTA_BITS;
   localparam int TB = dtq_pkg::TAG_BITS;

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_INS_RD  = 9'b000000010,
      ST_INS_CHK = 9'b000000100,
      ST_SH_RD   = 9'b000001000,
      ST_SH_WR   = 9'b000010000,
      ST_INS_WR  = 9'b000100000,
      ST_TK_RD   = 9'b001000000,
      ST_TK_CHK  = 9'b010000000,
      ST_TK_END  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [CB-1:0] count_ff, count_in;
   logic [IB-1:0] pos_ff, pos_in;
   logic [IB-1:0] shift_ff, shift_in;
   logic [DB-1:0] rem_ff, rem_in;
   logic [TB-1:0] tag_ff, tag_in;
   logic [15:0]   ticks_ff, ticks_in;
   logic          first_ff, first_in;
   logic          pend_ff, pend_in;
   logic [TB-1:0] pend_tag_ff, pend_tag_in;

   logic          rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]    rsp_kind_ff, rsp_kind_in;
   logic [7:0]    rsp_fired_tag_ff, rsp_fired_tag_in;
   logic          rsp_last_ff, rsp_last_in;

   dtq_pkg::mem_req_type mem_req;
   dtq_pkg::entry_type   rd_data;

   logic signed [DB:0] walk_diff;
   logic signed [DB:0] head_delta;
   logic               fire;
   logic [IB-1:0]      tail_idx;

   assign walk_diff = $signed({2'b00, rem_ff[DB-2:0]}) - $signed({rd_data.delta[DB-1],
                                                                  rd_data.delta});
   // only the head takes the tick count, later entries fire only at zero
   assign head_delta = first_ff ?
                       $signed({rd_data.delta[DB-1], rd_data.delta}) -
                       $signed({(DB+1-16)'(0), ticks_ff}) :
                       $signed({rd_data.delta[DB-1], rd_data.delta});
   assign fire     = (head_delta <= 0);
   assign tail_idx = IB'(count_ff - CB'(1));

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      pos_in      = pos_ff;
      shift_in    = shift_ff;
      rem_in      = rem_ff;
      tag_in      = tag_ff;
      ticks_in    = ticks_ff;
      first_in    = first_ff;
      pend_in     = pend_ff;
      pend_tag_in = pend_tag_ff;

      rsp_strobe_in    = 1'b0;
      rsp_kind_in      = dtq_pkg::KIND_ACCEPT;
      rsp_fired_tag_in = '0;
      rsp_last_in      = 1'b0;

      mem_req         = '0;
      mem_req.wr_data = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_cmd == dtq_pkg::CMD_INSERT) begin
                  if (count_ff == CB'(dtq_pkg::DEPTH)) begin
                     rsp_strobe_in = 1'b1;
                     rsp_kind_in   = dtq_pkg::KIND_FULL;
                     rsp_last_in   = 1'b1;
                  end else begin
                     rem_in   = {1'b0, req_delay};
                     tag_in   = TB'(req_event_tag);
                     pos_in   = '0;
                     state_in = ST_INS_RD;
                  end
               end else begin
                  ticks_in = req_tick_count;
                  first_in = 1'b1;
                  pend_in  = 1'b0;
                  if (count_ff != '0) begin
                     state_in = ST_TK_RD;
                  end
               end
            end
         end
         ST_INS_RD: begin
            if (CB'(pos_ff) == count_ff) begin
               state_in = ST_INS_WR;
            end else if (rem_ff == '0) begin
               shift_in = tail_idx;
               state_in = ST_SH_RD;
            end else begin
               mem_req.rd_en  = 1'b1;
               mem_req.rd_idx = pos_ff;
               state_in       = ST_INS_CHK;
            end
         end
         ST_INS_CHK: begin
            if (walk_diff > 0) begin
               rem_in   = walk_diff[DB-1:0];
               pos_in   = pos_ff + IB'(1);
               state_in = ST_INS_RD;
            end else begin
               shift_in = tail_idx;
               state_in = ST_SH_RD;
            end
         end
         ST_SH_RD: begin
            mem_req.rd_en  = 1'b1;
            mem_req.rd_idx = shift_ff;
            state_in       = ST_SH_WR;
         end
         ST_SH_WR: begin
            // move one entry up; the one at the slot gives up the new event's delta
            mem_req.wr_en   = 1'b1;
            mem_req.wr_idx  = shift_ff + IB'(1);
            mem_req.wr_data = rd_data;
            if (shift_ff == pos_ff) begin
               mem_req.wr_data.delta = rd_data.delta - rem_ff;
               state_in              = ST_INS_WR;
            end else begin
               shift_in = shift_ff - IB'(1);
               state_in = ST_SH_RD;
            end
         end
         ST_INS_WR: begin
            mem_req.wr_en         = 1'b1;
            mem_req.wr_idx        = pos_ff;
            mem_req.wr_data.delta = rem_ff;
            mem_req.wr_data.tag   = tag_ff;
            count_in              = count_ff + CB'(1);
            rsp_strobe_in         = 1'b1;
            rsp_kind_in           = dtq_pkg::KIND_ACCEPT;
            rsp_last_in           = 1'b1;
            state_in              = ST_IDLE;
         end
         ST_TK_RD: begin
            mem_req.rd_en  = 1'b1;
            mem_req.rd_idx = '0;
            state_in       = ST_TK_CHK;
         end
         ST_TK_CHK: begin
            first_in = 1'b0;
            // a fired event is held back in pend until we know whether it is the last
            if (fire) begin
               if (pend_ff) begin
                  rsp_strobe_in    = 1'b1;
                  rsp_kind_in      = dtq_pkg::KIND_FIRED;
                  rsp_fired_tag_in = 8'(pend_tag_ff);
               end
               pend_in     = 1'b1;
               pend_tag_in = rd_data.tag;
               mem_req.pop = 1'b1;
               count_in    = count_ff - CB'(1);
               state_in    = (count_ff == CB'(1)) ? ST_TK_END : ST_TK_RD;
            end else begin
               if (pend_ff) begin
                  rsp_strobe_in    = 1'b1;
                  rsp_kind_in      = dtq_pkg::KIND_FIRED;
                  rsp_fired_tag_in = 8'(pend_tag_ff);
                  rsp_last_in      = 1'b1;
               end else begin
                  mem_req.wr_en         = 1'b1;
                  mem_req.wr_idx        = '0;
                  mem_req.wr_data.delta = head_delta[DB-1:0];
                  mem_req.wr_data.tag   = rd_data.tag;
               end
               state_in = ST_IDLE;
            end
         end
         ST_TK_END: begin
            rsp_strobe_in    = 1'b1;
            rsp_kind_in      = dtq_pkg::KIND_FIRED;
            rsp_fired_tag_in = 8'(pend_tag_ff);
            rsp_last_in      = 1'b1;
            pend_in          = 1'b0;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         first_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_ff       <= pend_in;
         first_ff      <= first_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff           <= pos_in;
      shift_ff         <= shift_in;
      rem_ff           <= rem_in;
      tag_ff           <= tag_in;
      ticks_ff         <= ticks_in;
      pend_tag_ff      <= pend_tag_in;
      rsp_kind_ff      <= rsp_kind_in;
      rsp_fired_tag_ff <= rsp_fired_tag_in;
      rsp_last_ff      <= rsp_last_in;
   end

   dtq_ring u_ring (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_fired_tag = rsp_fired_tag_ff;
   assign rsp_last      = rsp_last_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(dtq_pkg::DEPTH))
      else $error("entry count above queue depth");

   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      !(mem_req.rd_en && mem_req.wr_en && mem_req.rd_idx == mem_req.wr_idx))
      else $error("read and write of the same entry in one cycle");

   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd == dtq_pkg::CMD_INSERT &&
       count_ff == CB'(dtq_pkg::DEPTH))
      |=> (rsp_strobe && rsp_kind == dtq_pkg::KIND_FULL && rsp_last))
      else $error("insert into full queue not rejected");

   a_insert_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_kind != dtq_pkg::KIND_FIRED) |-> rsp_last)
      else $error("insert transaction result not flagged last");

   a_pop_from_tick: assert property (@(posedge clock) disable iff (reset)
      mem_req.pop |-> (state_ff == ST_TK_CHK && count_ff != '0))
      else $error("pop outside tick or on empty queue");

endmodule
